FILE: design/smtp_pkg.sv
package smtp_pkg;

  localparam int SMP_W   = 16;
  localparam int CRD_W   = 10;
  localparam int CRD_MAX = (1 << CRD_W) - 1;
  localparam int GAIN_W  = 32;
  localparam int PIX_W   = 8;
  localparam int SQ_W    = 32;               // re^2 + im^2 <= 2^31
  localparam int ROOT_W  = 24;               // magnitude, Q.8
  localparam int REM_W   = 26;               // remainder <= 2*root
  localparam int PROD_W  = ROOT_W + GAIN_W;  // magnitude * gain
  localparam int FRAC_W  = 24;               // fraction bits of the product
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_GAIN = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SWAP = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RST = 32'h0001_0000;  // 1.0 in Q16.16
  localparam logic              SWAP_RST = 1'b1;
  localparam logic [PIX_W-1:0]  PIX_MAX  = 8'hFF;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_re;
    logic signed [SMP_W-1:0] sample_im;
    logic [CRD_W-1:0]        src_row;
    logic [CRD_W-1:0]        src_col;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [CRD_W-1:0] dst_row;
    logic [CRD_W-1:0] dst_col;
  } out_item_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] idx;
    logic [GAIN_W-1:0]    value;
  } cfg_item_t;

  // per-stage control travelling with an item
  typedef struct packed {
    logic valid;
    logic wrap;
  } ctl_t;

  // square-root working set handed from cell to cell
  typedef struct packed {
    logic [SQ_W-1:0]   sq;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } lane_t;

endpackage

FILE: design/smtp_chan_if.sv
interface smtp_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/spectrum_magnitude_to_pixel.sv
// Channel   Modport  Payload                                   Handshake
// in_ch     sink     sample_re, sample_im, src_row, src_col    valid/ready
// out_ch    source   pixel, dst_row, dst_col                   valid/ready
// cfg_ch    sink     idx (0 gain, 1 swap_quadrants), value     valid/ready, ready always 1
//
// One item per clock unless the skid is full. Stages from accept to out_ch.valid: two front
// stages (squares, sum), 24 square-root cells, one multiply stage, output reg.
// The root chain has 24 cells, one root bit per cell.
// rst_n is synchronous; it clears valid bits and loads gain = 1.0, swap = 1.
// A stalled result moves into a one-item skid; in_ch.ready drops only while
// the skid is full, and the whole pipeline holds with it.
module spectrum_magnitude_to_pixel #(
  parameter int DIM = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  smtp_chan_if.sink   in_ch,
  smtp_chan_if.source out_ch,
  smtp_chan_if.sink   cfg_ch
);

  localparam int NCELL = smtp_pkg::ROOT_W;
  // widest coordinate after adding the half-frame offset
  localparam int SUM_W = $clog2(smtp_pkg::CRD_MAX + DIM / 2 + 1);

  // configuration registers
  logic [smtp_pkg::GAIN_W-1:0] gain_r;
  logic                        swap_r;

  // pipeline
  logic                en;
  smtp_pkg::ctl_t      ctl   [0:NCELL];
  smtp_pkg::lane_t     lane  [0:NCELL];
  logic [SUM_W-1:0]    row_c [0:NCELL];
  logic [SUM_W-1:0]    col_c [0:NCELL];
  logic                last_valid;
  smtp_pkg::out_item_t last_item;

  // output register and skid
  logic                out_valid_r, skid_valid_r;
  smtp_pkg::out_item_t out_r, skid_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= smtp_pkg::GAIN_RST;
      swap_r <= smtp_pkg::SWAP_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.idx)
        smtp_pkg::REG_GAIN: gain_r <= cfg_ch.data.value;
        smtp_pkg::REG_SWAP: swap_r <= cfg_ch.data.value[0];
      endcase
    end
  end

  // the whole pipeline moves unless the skid already holds an item
  assign en          = !skid_valid_r;
  assign in_ch.ready = en;

  smtp_front #(
    .DIM   (DIM),
    .SUM_W (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .in_item  (in_ch.data),
    .swap     (swap_r),
    .ctl_o    (ctl[0]),
    .lane_o   (lane[0]),
    .row_o    (row_c[0]),
    .col_o    (col_c[0])
  );

  // Cell i finds root bit 23-i. The first SUM_W cells also take DIM << k off
  // a wrapped coordinate when it fits, k from SUM_W-1 down to 0: a long
  // division by the frame size that leaves the remainder.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    localparam int          SH  = (i < SUM_W) ? (SUM_W - 1 - i) : 0;
    localparam int unsigned SUB = (i < SUM_W) ? (int'(unsigned'(DIM)) << SH) : 0;
    smtp_cell #(
      .STEP  (NCELL - 1 - i),
      .SUM_W (SUM_W),
      .SUB   (SUB)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl[i]),
      .lane_i (lane[i]),
      .row_i  (row_c[i]),
      .col_i  (col_c[i]),
      .ctl_o  (ctl[i+1]),
      .lane_o (lane[i+1]),
      .row_o  (row_c[i+1]),
      .col_o  (col_c[i+1])
    );
  end

  // destination fields keep the low coordinate bits
  smtp_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (ctl[NCELL]),
    .root_i  (lane[NCELL].root),
    .row_i   (row_c[NCELL][smtp_pkg::CRD_W-1:0]),
    .col_i   (col_c[NCELL][smtp_pkg::CRD_W-1:0]),
    .gain    (gain_r),
    .valid_o (last_valid),
    .item_o  (last_item)
  );

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ch.ready) skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= last_valid;
    end else if (last_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ch.ready) out_r <= skid_r;
    end else if (!out_valid_r || out_ch.ready) begin
      out_r <= last_item;
    end else begin
      skid_r <= last_item;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item with the output register empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ch.ready))
    else $error("skid loaded without an output stall");

  a_skid_held: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_ch.ready |=> skid_valid_r)
    else $error("skid item dropped without a handshake");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    en && last_valid |=> out_valid_r)
    else $error("result leaving the pipeline was lost");
`endif

endmodule

FILE: design/smtp_front.sv
module smtp_front #(
  parameter int DIM   = 1024,
  parameter int SUM_W = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  smtp_pkg::in_item_t  in_item,
  input  logic                swap,
  output smtp_pkg::ctl_t      ctl_o,
  output smtp_pkg::lane_t     lane_o,
  output logic [SUM_W-1:0]    row_o,
  output logic [SUM_W-1:0]    col_o
);

  localparam logic [SUM_W-1:0] HALF_N = SUM_W'(DIM / 2);

  logic signed [2*smtp_pkg::SMP_W-1:0] re_sq, im_sq;
  logic [smtp_pkg::SQ_W-2:0] re_sq_r, im_sq_r;
  logic [SUM_W-1:0] row_a_r, col_a_r, row_a_nxt, col_a_nxt;
  smtp_pkg::ctl_t ctl_a_r, ctl_b_r;
  smtp_pkg::lane_t lane_b_r;
  logic [SUM_W-1:0] row_b_r, col_b_r;

  assign re_sq = in_item.sample_re * in_item.sample_re;
  assign im_sq = in_item.sample_im * in_item.sample_im;
  assign row_a_nxt = SUM_W'(in_item.src_row) + (swap ? HALF_N : '0);
  assign col_a_nxt = SUM_W'(in_item.src_col) + (swap ? HALF_N : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else if (en) begin
      ctl_a_r <= '{valid: in_valid, wrap: swap};
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_sq_r       <= (smtp_pkg::SQ_W-1)'(re_sq);
      im_sq_r       <= (smtp_pkg::SQ_W-1)'(im_sq);
      row_a_r       <= row_a_nxt;
      col_a_r       <= col_a_nxt;
      lane_b_r.sq   <= smtp_pkg::SQ_W'(re_sq_r) + smtp_pkg::SQ_W'(im_sq_r);
      lane_b_r.rem  <= '0;
      lane_b_r.root <= '0;
      row_b_r       <= row_a_r;
      col_b_r       <= col_a_r;
    end
  end

  assign ctl_o  = ctl_b_r;
  assign lane_o = lane_b_r;
  assign row_o  = row_b_r;
  assign col_o  = col_b_r;

endmodule

FILE: design/smtp_cell.sv
// One root bit per cell (restoring square root) plus one conditional
// subtract on each coordinate for the modulo.
module smtp_cell #(
  parameter int          STEP  = 23,
  parameter int          SUM_W = 11,
  parameter int unsigned SUB   = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  smtp_pkg::ctl_t   ctl_i,
  input  smtp_pkg::lane_t  lane_i,
  input  logic [SUM_W-1:0] row_i,
  input  logic [SUM_W-1:0] col_i,
  output smtp_pkg::ctl_t   ctl_o,
  output smtp_pkg::lane_t  lane_o,
  output logic [SUM_W-1:0] row_o,
  output logic [SUM_W-1:0] col_o
);

  localparam int CUR_W = smtp_pkg::REM_W + 2;
  localparam int VAL_W = smtp_pkg::SQ_W + 16;
  localparam logic [SUM_W-1:0] SUB_N = SUM_W'(SUB);

  logic [VAL_W-1:0] v;
  logic [CUR_W-1:0] cur, trial;
  logic             ge;
  smtp_pkg::ctl_t   ctl_r;
  smtp_pkg::lane_t  lane_r, lane_nxt;
  logic [SUM_W-1:0] row_r, col_r, row_nxt, col_nxt;

  // radicand is sq << 16: eight extra root bits of fraction
  assign v     = {lane_i.sq, 16'h0000};
  assign cur   = {lane_i.rem, v[2*STEP +: 2]};
  assign trial = CUR_W'({lane_i.root, 2'b01});
  assign ge    = (cur >= trial);

  always_comb begin
    lane_nxt.sq   = lane_i.sq;
    lane_nxt.rem  = smtp_pkg::REM_W'(ge ? (cur - trial) : cur);
    lane_nxt.root = {lane_i.root[smtp_pkg::ROOT_W-2:0], ge};
    row_nxt = row_i;
    col_nxt = col_i;
    if (ctl_i.wrap && (32'(row_i) >= SUB)) row_nxt = row_i - SUB_N;
    if (ctl_i.wrap && (32'(col_i) >= SUB)) col_nxt = col_i - SUB_N;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign lane_o = lane_r;
  assign row_o  = row_r;
  assign col_o  = col_r;

endmodule

FILE: design/smtp_scale.sv
module smtp_scale (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  smtp_pkg::ctl_t                      ctl_i,
  input  logic [smtp_pkg::ROOT_W-1:0]         root_i,
  input  logic [smtp_pkg::CRD_W-1:0]          row_i,
  input  logic [smtp_pkg::CRD_W-1:0]          col_i,
  input  logic [smtp_pkg::GAIN_W-1:0]         gain,
  output logic                                valid_o,
  output smtp_pkg::out_item_t                 item_o
);

  logic [smtp_pkg::PROD_W-1:0] prod_r;
  logic [smtp_pkg::CRD_W-1:0]  row_r, col_r;
  logic                        valid_r;
  logic                        sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= smtp_pkg::PROD_W'(root_i) * smtp_pkg::PROD_W'(gain);
      row_r  <= row_i;
      col_r  <= col_i;
    end
  end

  // integer part above 255 saturates
  assign sat = |prod_r[smtp_pkg::PROD_W-1:smtp_pkg::FRAC_W+smtp_pkg::PIX_W];

  assign valid_o        = valid_r;
  assign item_o.pixel   = sat ? smtp_pkg::PIX_MAX
                              : prod_r[smtp_pkg::FRAC_W +: smtp_pkg::PIX_W];
  assign item_o.dst_row = row_r;
  assign item_o.dst_col = col_r;

endmodule

FILE: tb/sv/spectrum_magnitude_to_pixel_tb.sv
module spectrum_magnitude_to_pixel_tb;
  import smtp_pkg::*;

  // Frame size of the instance under test; the prediction follows it.
  localparam int DIM = 1024;
  // Accept to out valid.
  localparam int LATENCY = 28;

  logic clk;
  logic rst_n;

  smtp_chan_if #(.T(in_item_t))  in_if ();
  smtp_chan_if #(.T(out_item_t)) out_if ();
  smtp_chan_if #(.T(cfg_item_t)) cfg_if ();

  spectrum_magnitude_to_pixel #(
    .DIM(DIM)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  // Register copies used for prediction. They start at the documented reset
  // values and follow every accepted config write.
  logic [GAIN_W-1:0] gain_q = 32'd65536;   // 1.0 in Q16.16
  logic              swap_q = 1'b1;

  // Pixels still owed by the block, oldest first.
  out_item_t pending_pixels[$];
  int        fault_count   = 0;

  // Traffic shaping: percent of cycles each side sits idle, plus a long
  // receiver hold-off that the receiver process counts down.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int stall_cycles  = 0;

  // ------------------------------------------------------------------
  // Clock and watchdog
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Timeout allows far more time than the slowest legal run needs.
  initial begin
    #(4 * 200000);
    $display("spectrum_magnitude_to_pixel_tb NOT OK");
    $finish;
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  // Largest r with r*r <= v, found one root bit at a time from the top.
  // v stays below 2^48 here, so the root fits in 24 bits.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Quadrant swap: move by half the frame, wrap at the frame size, then keep
  // what fits in the coordinate field.
  function automatic logic [CRD_W-1:0] shift_coord(input logic [CRD_W-1:0] c);
    int unsigned d;
    d = 32'(c);
    if (swap_q) d = (d + DIM / 2) % DIM;
    return d[CRD_W-1:0];
  endfunction

  function automatic out_item_t render_pixel(input in_item_t s);
    longint          re;
    longint          im;
    longint unsigned energy;
    longint unsigned mag_q8;
    longint unsigned level;
    out_item_t       o;
    re     = longint'($signed(s.sample_re));
    im     = longint'($signed(s.sample_im));
    energy = re * re + im * im;              // exact, at most 2^31
    mag_q8 = floor_root(energy << 16);       // magnitude with 8 fraction bits
    level  = (mag_q8 * gain_q) >> 24;        // drop 8 + 16 fraction bits
    o.pixel   = (level > 255) ? 8'd255 : level[PIX_W-1:0];
    o.dst_row = shift_coord(s.src_row);
    o.dst_col = shift_coord(s.src_col);
    return o;
  endfunction

  // ------------------------------------------------------------------
  // Receiver: random ready, or held low while a hold-off is counting down
  // ------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_cycles > 0) begin
        stall_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // ------------------------------------------------------------------
  // Result checker: every accepted item against the oldest prediction
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pixels.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected item: pixel %0d row %0d col %0d",
                   out_if.data.pixel, out_if.data.dst_row, out_if.data.dst_col);
      end else begin
        want = pending_pixels.pop_front();
        if (out_if.data.pixel !== want.pixel || out_if.data.dst_row !== want.dst_row ||
            out_if.data.dst_col !== want.dst_col) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: pixel %0d/%0d row %0d/%0d col %0d/%0d (want/got)",
                     want.pixel, out_if.data.pixel, want.dst_row, out_if.data.dst_row,
                     want.dst_col, out_if.data.dst_col);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Shared stimulus tasks
  // ------------------------------------------------------------------

  // Offer one sample, after a random idle stretch, and log its prediction at
  // the accepting edge. Valid stays high on return so back-to-back items keep
  // it asserted without a drop.
  task automatic send_sample(input in_item_t smp);
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= smp;
    do @(posedge clk); while (!in_if.ready);
    pending_pixels.push_back(render_pixel(smp));
  endtask

  // Stop offering and wait until every owed pixel has come out.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Register write; only called with the pipeline empty.
  task automatic write_reg(input logic [REG_IDX_W-1:0] reg_idx,
                           input logic [GAIN_W-1:0] reg_val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{idx: reg_idx, value: reg_val};
    do @(posedge clk); while (!cfg_if.ready);
    if (reg_idx == REG_GAIN) gain_q = reg_val;
    else                     swap_q = reg_val[0];
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic [GAIN_W-1:0] g, input logic swap);
    drain_results();
    write_reg(REG_GAIN, g);
    write_reg(REG_SWAP, {{(GAIN_W-1){1'b0}}, swap});
  endtask

  function automatic in_item_t sample_at(input int re, input int im,
                                         input int row, input int col);
    in_item_t s;
    s.sample_re = re[SMP_W-1:0];
    s.sample_im = im[SMP_W-1:0];
    s.src_row   = row[CRD_W-1:0];
    s.src_col   = col[CRD_W-1:0];
    return s;
  endfunction

  // Random content with a random amplitude so pixels land across the whole
  // 0..255 range and not only at saturation.
  function automatic in_item_t random_sample();
    in_item_t s;
    int       sh;
    sh = $urandom_range(15);
    s.sample_re = $signed(SMP_W'($urandom)) >>> sh;
    s.sample_im = $signed(SMP_W'($urandom)) >>> sh;
    s.src_row   = CRD_W'($urandom_range(CRD_MAX));
    s.src_col   = CRD_W'($urandom_range(CRD_MAX));
    return s;
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return $urandom_range(1023);
      2:       return 32'd1 << $urandom_range(31);
      3:       return $urandom_range(32'h0004_0000);
      4:       return 32'hFFFF_FFFF;
      default: return 32'd0;
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Reset registers (gain 1.0, swap on): field extremes, saturation,
  // most negative input, and the coordinate wrap at the frame halves.
  task automatic test_reset_defaults();
    send_sample(sample_at(0, 0, 0, 0));
    send_sample(sample_at(1, 0, 1023, 1023));
    send_sample(sample_at(3, 4, 511, 512));
    send_sample(sample_at(-1, 1, 512, 511));
    send_sample(sample_at(255, 0, 100, 900));
    send_sample(sample_at(256, 0, 1, 2));
    send_sample(sample_at(32767, 32767, 0, 1023));
    send_sample(sample_at(-32768, -32768, 1023, 0));
    send_sample(sample_at(0, -32768, 700, 300));
  endtask

  // Gain of zero, the largest and the smallest nonzero gain, a gain of 0.5, and swap off.
  task automatic test_gain_extremes();
    set_mode(32'd0, 1'b1);
    send_sample(sample_at(-32768, -32768, 5, 6));
    send_sample(sample_at(100, -100, 512, 0));
    set_mode(32'hFFFF_FFFF, 1'b0);
    send_sample(sample_at(0, 0, 0, 1023));
    send_sample(sample_at(1, 0, 1023, 0));
    send_sample(sample_at(0, -32768, 511, 512));
    set_mode(32'd1, 1'b0);
    send_sample(sample_at(-32768, -32768, 300, 700));
    set_mode(32'h0000_8000, 1'b1);             // 0.5: odd magnitudes round down
    send_sample(sample_at(3, 0, 10, 20));
    send_sample(sample_at(-511, 0, 1000, 1));
  endtask

  // Receiver holds off long enough for the pipeline and skid to fill, while
  // the sender keeps offering back to back; then the sender pauses until the
  // block is empty and resumes.
  task automatic test_backpressure();
    set_mode(32'h0000_0800, 1'b1);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    stall_cycles  = 300;
    repeat (150) send_sample(random_sample());
    drain_results();
    repeat (30) send_sample(random_sample());
  endtask

  // Random samples under a new register setting per batch; swap alternates.
  task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                     input int batches, input int per_batch);
    for (int b = 0; b < batches; b++) begin
      set_mode(random_gain(), b[0]);
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      repeat (per_batch) send_sample(random_sample());
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_gain_extremes();
    test_backpressure();
    test_random_traffic(25, 49, 4, 85);
    test_random_traffic(49, 25, 4, 85);
    test_random_traffic(0, 0, 4, 85);

    // Let the tail drain, then watch a little longer for stray items.
    drain_results();
    repeat (LATENCY + 8) @(posedge clk);
    if (fault_count == 0 && pending_pixels.size() == 0) begin
      $display("spectrum_magnitude_to_pixel_tb OK");
    end else begin
      $display("spectrum_magnitude_to_pixel_tb NOT OK");
    end
    $finish;
  end

endmodule
